### src/cdsu_pkg.sv
// Shared types, calendar constants and helper functions for the calendar date serial unit.
package cdsu_pkg;

  // Calendar span and defaults
  localparam int FIRST_YEAR   = 1900;
  localparam int LAST_YEAR    = 2099;
  localparam int DEFAULT_YEAR = 2000;
  localparam int FALLBACK_YEAR =
    (DEFAULT_YEAR >= FIRST_YEAR && DEFAULT_YEAR <= LAST_YEAR) ? DEFAULT_YEAR : FIRST_YEAR;

  localparam int DAYS_YEAR = 365;
  localparam int DAYS_LEAP = 366;

  // Serial of the last day of the span (serial 1 is the first day)
  localparam int LAST_SERIAL = DAYS_YEAR * (LAST_YEAR - FIRST_YEAR + 1)
    + (LAST_YEAR / 4 - LAST_YEAR / 100 + LAST_YEAR / 400)
    - ((FIRST_YEAR - 1) / 4 - (FIRST_YEAR - 1) / 100 + (FIRST_YEAR - 1) / 400);

  // Leap-rule counter start values for the first year
  localparam int FIRST_MOD4   = FIRST_YEAR % 4;
  localparam int FIRST_MOD100 = FIRST_YEAR % 100;
  localparam int FIRST_MOD400 = FIRST_YEAR % 400;

  typedef logic [11:0]        year_t;
  typedef logic [3:0]         month_t;
  typedef logic [4:0]         day_t;
  typedef logic [16:0]        serial_t;
  typedef logic signed [17:0] count_t;
  typedef logic signed [18:0] acc_t;
  typedef logic [8:0]         ylen_t;
  typedef logic [1:0]         op_t;

  // Operation codes
  localparam op_t OP_SERIAL_TO_DATE = 2'd0;
  localparam op_t OP_DATE_TO_SERIAL = 2'd1;
  localparam op_t OP_ADD_DAYS       = 2'd2;

  // Month numbers used for month lengths and the valid month range
  localparam month_t MON_JAN = 4'd1;
  localparam month_t MON_FEB = 4'd2;
  localparam month_t MON_APR = 4'd4;
  localparam month_t MON_JUN = 4'd6;
  localparam month_t MON_SEP = 4'd9;
  localparam month_t MON_NOV = 4'd11;
  localparam month_t MON_DEC = 4'd12;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TO_YEAR,
    ST_TO_MONTH,
    ST_SUM,
    ST_CLAMP,
    ST_FROM_YEAR,
    ST_FROM_MONTH,
    ST_FINISH
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic yr_step_to;
    logic mo_step_to;
    logic sum;
    logic clamp;
    logic yr_step_from;
    logic mo_step_from;
    logic emit;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic yr_done_to;
    logic mo_done_to;
    logic yr_done_from;
    logic mo_done_from;
    logic out_free;
  } sts_t;

  // Days in a month given the leap flag of its year
  function automatic day_t days_in_month_f(month_t month, logic leap);
    day_t len;
    unique case (month) inside
      MON_FEB:                            len = leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
      default:                            len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

### src/cdsu_ctrl.sv
// Sequencer state machine for the calendar date serial unit.
module cdsu_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cdsu_pkg::sts_t sts_i,
  output cdsu_pkg::cmd_t cmd_o
);
  import cdsu_pkg::*;

  state_e state_q, state_d;

  // Hold the current state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Select the next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:       if (in_valid_i) state_d = ST_TO_YEAR;
      ST_TO_YEAR:    if (sts_i.yr_done_to) state_d = ST_TO_MONTH;
      ST_TO_MONTH:   if (sts_i.mo_done_to) state_d = ST_SUM;
      ST_SUM:        state_d = ST_CLAMP;
      ST_CLAMP:      state_d = ST_FROM_YEAR;
      ST_FROM_YEAR:  if (sts_i.yr_done_from) state_d = ST_FROM_MONTH;
      ST_FROM_MONTH: if (sts_i.mo_done_from) state_d = ST_FINISH;
      ST_FINISH:     if (sts_i.out_free) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // Drive datapath commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_TO_YEAR:    cmd_o.yr_step_to   = !sts_i.yr_done_to;
      ST_TO_MONTH:   cmd_o.mo_step_to   = !sts_i.mo_done_to;
      ST_SUM:        cmd_o.sum          = 1'b1;
      ST_CLAMP:      cmd_o.clamp        = 1'b1;
      ST_FROM_YEAR:  cmd_o.yr_step_from = !sts_i.yr_done_from;
      ST_FROM_MONTH: cmd_o.mo_step_from = !sts_i.mo_done_from;
      ST_FINISH:     cmd_o.emit         = sts_i.out_free;
      default:       cmd_o = '0;
    endcase
  end

endmodule

### src/cdsu_dpath.sv
// Datapath of the calendar date serial unit: year and month walks, sum, clamp, result register.
module cdsu_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cdsu_pkg::cmd_t     cmd_i,
  output cdsu_pkg::sts_t     sts_o,
  input  cdsu_pkg::op_t      operation_i,
  input  cdsu_pkg::year_t    year_in_i,
  input  cdsu_pkg::month_t   month_in_i,
  input  cdsu_pkg::day_t     day_in_i,
  input  cdsu_pkg::count_t   count_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output cdsu_pkg::year_t    year_out_o,
  output cdsu_pkg::month_t   month_out_o,
  output cdsu_pkg::day_t     day_out_o,
  output cdsu_pkg::serial_t  serial_out_o,
  output logic              clamped_o
);
  import cdsu_pkg::*;

  // Item registers
  op_t     op_q;
  year_t   yv_q;
  month_t  mv_q;
  day_t    draw_q;
  count_t  count_q;

  // Walk registers
  year_t       yy_q;
  month_t      mm_q;
  logic [1:0]  c4_q;
  logic [6:0]  c100_q;
  logic [8:0]  c400_q;
  acc_t        acc_q;
  serial_t     serial_q;
  logic        clamped_q;

  // Result register
  logic    out_valid_q;
  year_t   year_out_q;
  month_t  month_out_q;
  day_t    day_out_q;
  serial_t serial_out_q;
  logic    clamped_out_q;

  logic    leap;
  ylen_t   year_len;
  day_t    mon_len;
  day_t    mv_len;
  day_t    day_fixed;
  logic    op_serial;
  year_t   year_valid;
  month_t  month_valid;
  acc_t    add_term;
  acc_t    sum_val;
  serial_t serial_sat;
  logic    sat_flag;

  // Leap flag and lengths of the current year and month
  always_comb begin
    leap      = (c4_q == 2'd0) && ((c100_q != 7'd0) || (c400_q == 9'd0));
    year_len  = leap ? ylen_t'(DAYS_LEAP) : ylen_t'(DAYS_YEAR);
    mon_len   = days_in_month_f(mm_q, leap);
    mv_len    = days_in_month_f(mv_q, leap);
    op_serial = (op_q == OP_SERIAL_TO_DATE);
  end

  // Validate the incoming year and month
  always_comb begin
    year_valid  = ((year_in_i < year_t'(FIRST_YEAR)) || (year_in_i > year_t'(LAST_YEAR)))
                  ? year_t'(FALLBACK_YEAR) : year_in_i;
    month_valid = ((month_in_i < MON_JAN) || (month_in_i > MON_DEC)) ? MON_JAN : month_in_i;
  end

  // Form the serial and saturate it
  always_comb begin
    day_fixed  = ((draw_q == 5'd0) || (draw_q > mv_len)) ? 5'd1 : draw_q;
    add_term   = (op_q == OP_ADD_DAYS) ? acc_t'(count_q) : '0;
    sum_val    = acc_q + $signed({14'd0, day_fixed}) + add_term;
    sat_flag   = 1'b0;
    serial_sat = acc_q[16:0];
    if (acc_q < 19'sd1) begin
      serial_sat = serial_t'(1);
      sat_flag   = 1'b1;
    end else if (acc_q > $signed(19'(LAST_SERIAL))) begin
      serial_sat = serial_t'(LAST_SERIAL);
      sat_flag   = 1'b1;
    end
  end

  // Status towards the controller
  always_comb begin
    sts_o.yr_done_to   = op_serial || (yy_q == yv_q);
    sts_o.mo_done_to   = op_serial || (mm_q == mv_q);
    sts_o.yr_done_from = (acc_q < $signed({10'd0, year_len})) ||
                         (yy_q >= year_t'(LAST_YEAR));
    sts_o.mo_done_from = (mm_q == MON_DEC) || (acc_q < $signed({14'd0, mon_len}));
    sts_o.out_free     = !out_valid_q || out_ready_i;
  end

  // Latch the item, walk years and months, sum and clamp
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= operation_i;
      yv_q    <= year_valid;
      mv_q    <= month_valid;
      draw_q  <= day_in_i;
      count_q <= count_i;
    end
    if (cmd_i.load || cmd_i.clamp) begin
      yy_q   <= year_t'(FIRST_YEAR);
      mm_q   <= MON_JAN;
      c4_q   <= 2'(FIRST_MOD4);
      c100_q <= 7'(FIRST_MOD100);
      c400_q <= 9'(FIRST_MOD400);
    end else if (cmd_i.yr_step_to || cmd_i.yr_step_from) begin
      yy_q   <= yy_q + 12'd1;
      c4_q   <= c4_q + 2'd1;
      c100_q <= (c100_q == 7'd99) ? 7'd0 : c100_q + 7'd1;
      c400_q <= (c400_q == 9'd399) ? 9'd0 : c400_q + 9'd1;
    end else if (cmd_i.mo_step_to || cmd_i.mo_step_from) begin
      mm_q <= mm_q + 4'd1;
    end
    if (cmd_i.load) begin
      acc_q <= '0;
    end else if (cmd_i.yr_step_to) begin
      acc_q <= acc_q + $signed({10'd0, year_len});
    end else if (cmd_i.mo_step_to) begin
      acc_q <= acc_q + $signed({14'd0, mon_len});
    end else if (cmd_i.sum) begin
      acc_q <= op_serial ? acc_t'(count_q) : sum_val;
    end else if (cmd_i.clamp) begin
      acc_q <= $signed({2'd0, serial_sat - serial_t'(1)});
    end else if (cmd_i.yr_step_from) begin
      acc_q <= acc_q - $signed({10'd0, year_len});
    end else if (cmd_i.mo_step_from) begin
      acc_q <= acc_q - $signed({14'd0, mon_len});
    end
    if (cmd_i.clamp) begin
      serial_q  <= serial_sat;
      clamped_q <= sat_flag;
    end
  end

  // Hold the result until the transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Capture result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      year_out_q    <= yy_q;
      month_out_q   <= mm_q;
      day_out_q     <= acc_q[4:0] + 5'd1;
      serial_out_q  <= serial_q;
      clamped_out_q <= clamped_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign year_out_o   = year_out_q;
  assign month_out_o  = month_out_q;
  assign day_out_o    = day_out_q;
  assign serial_out_o = serial_out_q;
  assign clamped_o    = clamped_out_q;

endmodule

### src/calendar_date_serial_unit_top.sv
// Top level of the calendar date serial unit: stream ports, sequencer and datapath.
//
//   Channel   Direction  Payload
//   s_axis    in         tuser: operation; tdata: year_in, month_in, day_in, count
//   m_axis    out        tuser: clamped;   tdata: year_out, month_out, day_out, serial_out
//
// One item at a time. A date input walks from the first year up to its year and from
// January to its month, then the saturated serial is walked back to a date by
// subtracting whole years and months in the shared accumulator.
// Reset clears the sequencer and the result valid flag only. A stalled result
// stays in the output register; the next item is taken once it has been queued
// there, even while it still waits.
module calendar_date_serial_unit_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  input  logic [39:0] s_axis_tdata,   // [11:0] year_in, [15:12] month_in, [20:16] day_in,
                                      // [38:21] count, [39] unused
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic        m_axis_tuser,   // [0] clamped
  output logic [39:0] m_axis_tdata    // [11:0] year_out, [15:12] month_out, [20:16] day_out,
                                      // [37:21] serial_out, [39:38] zero
);
  import cdsu_pkg::*;

  cmd_t    cmd;
  sts_t    sts;
  year_t   year_out;
  month_t  month_out;
  day_t    day_out;
  serial_t serial_out;

  // Sequencer
  cdsu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath
  cdsu_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .operation_i  (s_axis_tuser),
    .year_in_i    (s_axis_tdata[11:0]),
    .month_in_i   (s_axis_tdata[15:12]),
    .day_in_i     (s_axis_tdata[20:16]),
    .count_i      (s_axis_tdata[38:21]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .year_out_o   (year_out),
    .month_out_o  (month_out),
    .day_out_o    (day_out),
    .serial_out_o (serial_out),
    .clamped_o    (m_axis_tuser)
  );

  // Pack the result transaction
  assign m_axis_tdata = {2'b00, serial_out, day_out, month_out, year_out};

endmodule
